// ===== src/wjs_pkg.sv =====
package wjs_pkg;

    // Field widths
    localparam int VALUE_W = 16;
    localparam int UNION_W = 13;
    localparam int MATCH_W = 14;
    localparam int SIM_W   = 17;

    // Count bounds: union saturates at MAX_LENGTH, matches at twice that
    localparam int MAX_LENGTH = 4096;
    localparam int UNION_CAP  = MAX_LENGTH;
    localparam int MATCH_CAP  = 2 * MAX_LENGTH;

    // 1.0 in unsigned Q1.16
    localparam int SIM_ONE = 65536;

    // Divider: one quotient bit per step
    localparam int QUOT_W = SIM_W;
    localparam int STEP_W = $clog2(QUOT_W);

    // Depth of the count queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_a;
        logic signed [VALUE_W-1:0] value_b;
        logic                      last_element;
    } t_in_beat;

    typedef struct packed {
        logic [SIM_W-1:0]   similarity;
        logic [UNION_W-1:0] union_count;
        logic [MATCH_W-1:0] match_halves;
    } t_out_beat;

    // Finished counts of one vector pair
    typedef struct packed {
        logic [UNION_W-1:0] union_count;
        logic [MATCH_W-1:0] match_halves;
    } t_counts;

    // Queue handshake toward the back end
    typedef struct packed {
        logic    valid;
        t_counts counts;
    } t_queue_head;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_WAIT
    } t_div_state;

endpackage

// ===== src/wjs_front.sv =====
module wjs_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  wjs_pkg::t_in_beat   i_beat,
    output logic                o_push,
    output wjs_pkg::t_counts    o_counts
);

    logic [wjs_pkg::UNION_W-1:0] r_union;
    logic [wjs_pkg::MATCH_W-1:0] r_match;
    logic [wjs_pkg::UNION_W-1:0] n_union;
    logic [wjs_pkg::MATCH_W-1:0] n_match;
    logic                        pos_a;
    logic                        pos_b;
    logic [1:0]                  match_inc;
    logic [wjs_pkg::MATCH_W:0]   match_sum;

    // Classify the pair: nonpositive ratings count as absent
    assign pos_a = (i_beat.value_a > 0);
    assign pos_b = (i_beat.value_b > 0);
    assign match_inc = (i_beat.value_a == i_beat.value_b) ? 2'd2 : 2'd1;
    assign match_sum = {1'b0, r_match} + (wjs_pkg::MATCH_W + 1)'(match_inc);

    // Saturating counts including the current pair
    always_comb begin
        n_union = r_union;
        n_match = r_match;
        if ((pos_a || pos_b) && (r_union < wjs_pkg::UNION_W'(wjs_pkg::UNION_CAP))) begin
            n_union = r_union + wjs_pkg::UNION_W'(1);
        end
        if (pos_a && pos_b) begin
            if (match_sum > (wjs_pkg::MATCH_W + 1)'(wjs_pkg::MATCH_CAP)) begin
                n_match = wjs_pkg::MATCH_W'(wjs_pkg::MATCH_CAP);
            end else begin
                n_match = match_sum[wjs_pkg::MATCH_W-1:0];
            end
        end
    end

    // Hand off counts on the last beat
    assign o_push                = i_accept && i_beat.last_element;
    assign o_counts.union_count  = n_union;
    assign o_counts.match_halves = n_match;

    // Advance or clear the counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_union <= '0;
            r_match <= '0;
        end else if (i_accept) begin
            if (i_beat.last_element) begin
                r_union <= '0;
                r_match <= '0;
            end else begin
                r_union <= n_union;
                r_match <= n_match;
            end
        end
    end

endmodule

// ===== src/wjs_queue.sv =====
module wjs_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  wjs_pkg::t_counts      i_counts,
    output logic                  o_full,
    input  logic                  i_take,
    output wjs_pkg::t_queue_head  o_head
);

    localparam int PTR_W = $clog2(wjs_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(wjs_pkg::QUEUE_DEPTH + 1);

    wjs_pkg::t_counts  r_mem [wjs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_take;

    assign o_full  = (r_count == CNT_W'(wjs_pkg::QUEUE_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_take = i_take && (r_count != '0);

    assign o_head.valid  = (r_count != '0);
    assign o_head.counts = r_mem[r_rd_ptr];

    // Store incoming counts
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_counts;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(wjs_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_take) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(wjs_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_take) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_take && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== src/wjs_back.sv =====
module wjs_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wjs_pkg::t_queue_head  i_head,
    output logic                  o_take,
    output wjs_pkg::t_out_beat    o_result,
    output logic                  o_empty,
    input  logic                  i_pop
);

    wjs_pkg::t_div_state           r_state;
    wjs_pkg::t_div_state           n_state;
    logic [wjs_pkg::UNION_W-1:0]   r_div;
    logic [wjs_pkg::UNION_W-1:0]   n_div;
    logic [wjs_pkg::UNION_W-1:0]   r_rem;
    logic [wjs_pkg::UNION_W-1:0]   n_rem;
    logic [wjs_pkg::QUOT_W-1:0]    r_num;
    logic [wjs_pkg::QUOT_W-1:0]    n_num;
    logic [wjs_pkg::QUOT_W-1:0]    r_quot;
    logic [wjs_pkg::QUOT_W-1:0]    n_quot;
    logic [wjs_pkg::STEP_W-1:0]    r_step;
    logic [wjs_pkg::STEP_W-1:0]    n_step;
    logic [wjs_pkg::MATCH_W-1:0]   r_match;
    logic [wjs_pkg::MATCH_W-1:0]   n_match;
    wjs_pkg::t_out_beat            r_out;
    wjs_pkg::t_out_beat            n_out;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic [wjs_pkg::UNION_W:0]     trial;
    logic                          fits;
    logic                          out_free;
    logic [wjs_pkg::QUOT_W-1:0]    sim;

    assign out_free = !r_out_valid || i_pop;
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {r_rem, r_num[wjs_pkg::QUOT_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    // Ratio is bounded by 1.0; clamp anyway
    assign sim = (r_quot > wjs_pkg::QUOT_W'(wjs_pkg::SIM_ONE)) ?
                 wjs_pkg::QUOT_W'(wjs_pkg::SIM_ONE) : r_quot;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wjs_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the datapath
    always_ff @(posedge i_clk) begin
        r_div   <= n_div;
        r_rem   <= n_rem;
        r_num   <= n_num;
        r_quot  <= n_quot;
        r_step  <= n_step;
        r_match <= n_match;
        r_out   <= n_out;
    end

    // Sequence: take counts, divide bit by bit (skipped when a count is zero), deliver the beat
    always_comb begin
        n_state     = r_state;
        n_div       = r_div;
        n_rem       = r_rem;
        n_num       = r_num;
        n_quot      = r_quot;
        n_step      = r_step;
        n_match     = r_match;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;
        o_take      = 1'b0;
        unique case (r_state)
            wjs_pkg::S_IDLE: begin
                if (i_head.valid) begin
                    o_take  = 1'b1;
                    n_div   = i_head.counts.union_count;
                    n_match = i_head.counts.match_halves;
                    // Dividend is match * 2^15; top bits seed the remainder
                    n_rem   = wjs_pkg::UNION_W'(i_head.counts.match_halves >> 2);
                    n_num   = {i_head.counts.match_halves[1:0],
                               (wjs_pkg::QUOT_W - 2)'(0)};
                    n_quot  = '0;
                    n_step  = wjs_pkg::STEP_W'(wjs_pkg::QUOT_W - 1);
                    if ((i_head.counts.union_count == '0) ||
                        (i_head.counts.match_halves == '0)) begin
                        n_state = wjs_pkg::S_WAIT;
                    end else begin
                        n_state = wjs_pkg::S_DIV;
                    end
                end
            end
            wjs_pkg::S_DIV: begin
                n_num  = {r_num[wjs_pkg::QUOT_W-2:0], 1'b0};
                n_quot = {r_quot[wjs_pkg::QUOT_W-2:0], fits};
                n_rem  = fits ? wjs_pkg::UNION_W'(trial - {1'b0, r_div}) :
                                trial[wjs_pkg::UNION_W-1:0];
                n_step = r_step - wjs_pkg::STEP_W'(1);
                if (r_step == '0) begin
                    n_state = wjs_pkg::S_WAIT;
                end
            end
            wjs_pkg::S_WAIT: begin
                if (out_free) begin
                    n_out.similarity   = sim;
                    n_out.union_count  = r_div;
                    n_out.match_halves = r_match;
                    n_out_valid        = 1'b1;
                    n_state            = wjs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wjs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/weighted_jaccard_similarity.sv =====
// Element beats: one per cycle while the count queue has room, counted in the front end.
// Result: queue hand-off, 17 divider steps and output load; the steps are skipped when
// either count is zero. The divider takes new counts only after loading the last result.
// A two-entry count queue lets new vectors stream while a ratio is divided.
// Synchronous active-low reset clears counters, queue pointers and fill level, divider state and result valid.
module weighted_jaccard_similarity (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  wjs_pkg::t_in_beat   i_beat,
    output logic                empty,
    input  logic                pop,
    output wjs_pkg::t_out_beat  o_result
);

    logic                  accept;
    logic                  cnt_push;
    logic                  take;
    wjs_pkg::t_counts      cnt_counts;
    wjs_pkg::t_queue_head  head;

    assign accept = push && !full;

    // Count element beats
    wjs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_beat   (i_beat),
        .o_push   (cnt_push),
        .o_counts (cnt_counts)
    );

    // Buffer finished counts
    wjs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (cnt_push),
        .i_counts (cnt_counts),
        .o_full   (full),
        .i_take   (take),
        .o_head   (head)
    );

    // Divide and deliver
    wjs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_take   (take),
        .o_result (o_result),
        .o_empty  (empty),
        .i_pop    (pop)
    );

endmodule

// ===== sim/tb_weighted_jaccard_similarity.sv =====
module tb_weighted_jaccard_similarity;

    // One queued element pair; drain_first holds it back until no result is owed
    typedef struct {
        wjs_pkg::t_in_beat beat;
        bit                drain_first;
    } t_pending_pair;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push    = 1'b0;
    logic               full;
    wjs_pkg::t_in_beat  i_beat  = '0;
    logic               empty;
    logic               pop     = 1'b0;
    wjs_pkg::t_out_beat o_result;

    t_pending_pair      pending_pairs[$];
    wjs_pkg::t_out_beat expected_scores[$];

    // Running counts of the vector pair in flight
    int union_run = 0;
    int match_run = 0;

    int error_count     = 0;
    int pair_count      = 0;
    int vector_count    = 0;
    int result_count    = 0;
    int saturated_count = 0;
    int zero_sim_count  = 0;
    int full_sim_count  = 0;

    // Sender burst shaping and receiver pop pattern
    int          burst_left  = 16;
    int          gap_left    = 0;
    logic [15:0] pop_pattern = '1;
    int          pop_phase   = 0;

    weighted_jaccard_similarity dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_beat   (i_beat),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("timeout with %0d pairs pending, %0d results owed",
                 pending_pairs.size(), expected_scores.size());
        $display("status: fail");
        $finish;
    end

    function automatic bit is_positive(logic [wjs_pkg::VALUE_W-1:0] v);
        return !v[wjs_pkg::VALUE_W-1] && (v != '0);
    endfunction

    // Count one accepted pair; on the last pair form the expected ratio and clear
    function automatic void score_pair(wjs_pkg::t_in_beat beat);
        bit                 pos_a;
        bit                 pos_b;
        int                 ratio;
        wjs_pkg::t_out_beat score;
        pos_a = is_positive(beat.value_a);
        pos_b = is_positive(beat.value_b);
        if (pos_a || pos_b) begin
            union_run = (union_run + 1 > wjs_pkg::UNION_CAP) ?
                        wjs_pkg::UNION_CAP : union_run + 1;
        end
        if (pos_a && pos_b) begin
            match_run += (beat.value_a == beat.value_b) ? 2 : 1;
            if (match_run > wjs_pkg::MATCH_CAP) match_run = wjs_pkg::MATCH_CAP;
        end
        if (beat.last_element) begin
            ratio = 0;
            if (union_run != 0 && match_run != 0) begin
                ratio = (match_run * 32768) / union_run;
                if (ratio > wjs_pkg::SIM_ONE) ratio = wjs_pkg::SIM_ONE;
            end
            score.similarity   = ratio[wjs_pkg::SIM_W-1:0];
            score.union_count  = union_run[wjs_pkg::UNION_W-1:0];
            score.match_halves = match_run[wjs_pkg::MATCH_W-1:0];
            expected_scores.insert(expected_scores.size(), score);
            if (union_run == wjs_pkg::UNION_CAP) saturated_count++;
            if (ratio == 0) zero_sim_count++;
            if (ratio == wjs_pkg::SIM_ONE) full_sim_count++;
            union_run = 0;
            match_run = 0;
        end
    endfunction

    function automatic void add_pair(logic [wjs_pkg::VALUE_W-1:0] a,
                                     logic [wjs_pkg::VALUE_W-1:0] b,
                                     bit last, bit drain);
        t_pending_pair p;
        p.beat.value_a      = a;
        p.beat.value_b      = b;
        p.beat.last_element = last;
        p.drain_first       = drain;
        pending_pairs.insert(pending_pairs.size(), p);
        pair_count++;
        if (last) vector_count++;
    endfunction

    // Mix of absent, small, extreme and full-range ratings
    function automatic logic [wjs_pkg::VALUE_W-1:0] rand_rating();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return 16'h8000 | 16'($urandom_range(0, 32767));
            2:       return 16'($urandom_range(1, 4));
            3:       return 16'($urandom);
            4:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom_range(1, 32767));
        endcase
    endfunction

    function automatic void add_vector(int len, int equal_pct, bit positive_only, bit drain);
        logic [wjs_pkg::VALUE_W-1:0] a;
        logic [wjs_pkg::VALUE_W-1:0] b;
        for (int i = 0; i < len; i++) begin
            a = positive_only ? 16'($urandom_range(1, 32767)) : rand_rating();
            if ($urandom_range(0, 99) < equal_pct) b = a;
            else b = positive_only ? 16'($urandom_range(1, 32767)) : rand_rating();
            add_pair(a, b, i == len - 1, drain && i == 0);
        end
    endfunction

    // Present the oldest pending pair during bursts; hold off on gaps and drains
    always @(negedge i_clk) begin
        bit offer;
        offer = 1'b0;
        if (i_rst_n && pending_pairs.size() != 0) begin
            if (pending_pairs[0].drain_first && expected_scores.size() != 0) begin
                offer = 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
            end else begin
                offer = 1'b1;
            end
        end
        push <= offer;
        if (offer) i_beat <= pending_pairs[0].beat;
    end

    // Walk a pop pattern, picking a new one whenever the phase count runs out
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop_phase == 0) begin
                pop_phase = $urandom_range(8, 64);
                case ($urandom_range(0, 3))
                    0:       pop_pattern = '1;
                    1:       pop_pattern = 16'($urandom);
                    2:       pop_pattern = 16'h8000;
                    default: pop_pattern = '0;
                endcase
            end
            pop <= pop_pattern[pop_phase % 16];
            pop_phase--;
        end
    end

    // Check popped results, then take in accepted pairs
    always @(posedge i_clk) begin
        wjs_pkg::t_out_beat want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_scores.size() == 0) begin
                    $display("%0t: result beat with none expected: %p", $time, o_result);
                    error_count++;
                end else begin
                    want = expected_scores.pop_front();
                    result_count++;
                    if (o_result.similarity !== want.similarity) begin
                        $display("%0t: similarity expected %0d, got %0d",
                                 $time, want.similarity, o_result.similarity);
                        error_count++;
                    end
                    if (o_result.union_count !== want.union_count) begin
                        $display("%0t: union_count expected %0d, got %0d",
                                 $time, want.union_count, o_result.union_count);
                        error_count++;
                    end
                    if (o_result.match_halves !== want.match_halves) begin
                        $display("%0t: match_halves expected %0d, got %0d",
                                 $time, want.match_halves, o_result.match_halves);
                        error_count++;
                    end
                end
            end
            if (push && !full) begin
                score_pair(pending_pairs[0].beat);
                void'(pending_pairs.pop_front());
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    initial begin
        int random_pairs;
        int len;

        // Directed: empty union, negatives, extremes, equal and unequal matches
        add_pair(16'h0000, 16'h0000, 1, 0);
        add_pair(16'h8000, 16'hFFFF, 1, 0);
        add_pair(16'h7FFF, 16'h7FFF, 1, 0);
        add_pair(16'h8000, 16'h7FFF, 1, 0);
        add_pair(16'h0001, 16'h0002, 0, 0);
        add_pair(16'h0005, 16'h0005, 0, 0);
        add_pair(16'h0000, 16'hFFF9, 0, 0);
        add_pair(16'h0007, 16'h0000, 1, 0);
        add_pair(16'h7FFF, 16'h7FFE, 1, 0);
        add_pair(16'h0001, 16'h0001, 0, 0);
        add_pair(16'h0002, 16'h0002, 0, 0);
        add_pair(16'h0003, 16'h0004, 1, 0);
        add_pair(16'h5555, 16'hAAAA, 1, 0);
        add_pair(16'hAAAA, 16'h5555, 1, 0);
        add_pair(16'h7FFF, 16'h0001, 0, 0);
        add_pair(16'h0000, 16'h0000, 1, 0);

        // Random vectors, mostly short, some drained before they start
        random_pairs = 0;
        while (random_pairs < 1060) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(1, 8);
                6, 7, 8:          len = $urandom_range(9, 40);
                default:          len = $urandom_range(41, 200);
            endcase
            add_vector(len, $urandom_range(0, 100), $urandom_range(0, 3) == 0,
                       random_pairs == 0 || $urandom_range(0, 29) == 0);
            random_pairs += len;
        end

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_pairs.size() != 0 || expected_scores.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("sent %0d pairs in %0d vectors, checked %0d results",
                 pair_count, vector_count, result_count);
        $display("%0d with saturated union, %0d at zero similarity, %0d at 1.0",
                 saturated_count, zero_sim_count, full_sim_count);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
